// ===== sv/tutk_pkg.sv =====
// tutk_pkg: shared widths, constants, command codes, leap-second table,
// divider request/response structs and the sequencer microcode program.
// No dependencies.
package tutk_pkg;

    localparam int CMD_W      = 2;
    localparam int TICK_W     = 32;
    localparam int SEC_W      = 31;
    localparam int RATE_W     = 16;
    localparam int USEC_W     = 20;
    localparam int DIVD_W     = 36;
    localparam int CNT_W      = $clog2(DIVD_W + 1);
    localparam int LEAP_IDX_W = 5;

    localparam logic [RATE_W-1:0]     RATE_RESET   = 16'd60;
    localparam logic [SEC_W-1:0]      SEC_MAX      = 31'h7FFF_FFFF;
    localparam logic [USEC_W-1:0]     USEC_PER_SEC = 20'd1000000;
    localparam logic [LEAP_IDX_W-1:0] LEAP_LAST    = 5'd26;
    localparam logic [CNT_W-1:0]      DIV_STEPS    = CNT_W'(DIVD_W);

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_DENIED = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_POSIX = 2'd0,
        CMD_UTC   = 2'd1,
        CMD_SET   = 2'd2
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [RATE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic [DIVD_W-1:0] quo;
        logic [RATE_W-1:0] rem;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_WAIT, S_DIV1, S_DIVW1, S_SAVE1, S_MUL, S_DIV2,
        S_DIVW2, S_SAVE2, S_LEAP, S_OUT, S_SET
    } t_step;

    typedef enum logic [3:0] {
        OP_NOP, OP_DIV_TICKS, OP_SAVE_QR, OP_MUL, OP_DIV_PROD,
        OP_SAVE_USEC, OP_LEAP, OP_EMIT, OP_SET
    } t_uop;

    // stay on the current step while the hold condition is true
    typedef enum logic [2:0] {
        HOLD_NONE, HOLD_NO_INPUT, HOLD_DIV_BUSY, HOLD_LEAP_MORE, HOLD_OUT_BLOCKED
    } t_hold;

    typedef enum logic [1:0] {
        BR_NONE, BR_ALWAYS, BR_IS_SET, BR_NOT_UTC
    } t_br;

    typedef struct packed {
        t_uop  op;
        t_hold hold;
        t_br   br;
        t_step target;
    } t_uword;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{op: OP_NOP, hold: HOLD_NONE, br: BR_ALWAYS, target: S_WAIT};
        case (step)
            S_WAIT:  w = '{op: OP_NOP,       hold: HOLD_NO_INPUT,    br: BR_NONE,    target: S_WAIT};
            S_DIV1:  w = '{op: OP_DIV_TICKS, hold: HOLD_NONE,        br: BR_NONE,    target: S_WAIT};
            S_DIVW1: w = '{op: OP_NOP,       hold: HOLD_DIV_BUSY,    br: BR_NONE,    target: S_WAIT};
            S_SAVE1: w = '{op: OP_SAVE_QR,   hold: HOLD_NONE,        br: BR_IS_SET,  target: S_SET};
            S_MUL:   w = '{op: OP_MUL,       hold: HOLD_NONE,        br: BR_NONE,    target: S_WAIT};
            S_DIV2:  w = '{op: OP_DIV_PROD,  hold: HOLD_NONE,        br: BR_NONE,    target: S_WAIT};
            S_DIVW2: w = '{op: OP_NOP,       hold: HOLD_DIV_BUSY,    br: BR_NONE,    target: S_WAIT};
            S_SAVE2: w = '{op: OP_SAVE_USEC, hold: HOLD_NONE,        br: BR_NOT_UTC, target: S_OUT};
            S_LEAP:  w = '{op: OP_LEAP,      hold: HOLD_LEAP_MORE,   br: BR_NONE,    target: S_WAIT};
            S_OUT:   w = '{op: OP_EMIT,      hold: HOLD_OUT_BLOCKED, br: BR_ALWAYS,  target: S_WAIT};
            S_SET:   w = '{op: OP_SET,       hold: HOLD_NONE,        br: BR_ALWAYS,  target: S_OUT};
            default: w = '{op: OP_NOP,       hold: HOLD_NONE,        br: BR_ALWAYS,  target: S_WAIT};
        endcase
        return w;
    endfunction

    function automatic logic [SEC_W-1:0] leap_limit(input logic [LEAP_IDX_W-1:0] idx);
        logic [SEC_W-1:0] v;
        v = SEC_MAX;
        case (idx)
            5'd0:    v = 31'd78796799;
            5'd1:    v = 31'd94694399;
            5'd2:    v = 31'd126230399;
            5'd3:    v = 31'd157766399;
            5'd4:    v = 31'd189302399;
            5'd5:    v = 31'd220924799;
            5'd6:    v = 31'd252460799;
            5'd7:    v = 31'd283996799;
            5'd8:    v = 31'd315532799;
            5'd9:    v = 31'd362793599;
            5'd10:   v = 31'd394329599;
            5'd11:   v = 31'd425865599;
            5'd12:   v = 31'd489023999;
            5'd13:   v = 31'd567993599;
            5'd14:   v = 31'd631151999;
            5'd15:   v = 31'd662687999;
            5'd16:   v = 31'd709948799;
            5'd17:   v = 31'd741484799;
            5'd18:   v = 31'd773020799;
            5'd19:   v = 31'd820454399;
            5'd20:   v = 31'd867715199;
            5'd21:   v = 31'd915148799;
            5'd22:   v = 31'd1136073599;
            5'd23:   v = 31'd1230767999;
            5'd24:   v = 31'd1341100799;
            5'd25:   v = 31'd1435708799;
            5'd26:   v = 31'd1483228799;
            default: v = SEC_MAX;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/tutk_div.sv =====
// tutk_div: restoring divider, one quotient bit per cycle, 36-bit dividend
// by 16-bit divisor. Depends on tutk_pkg.
module tutk_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tutk_pkg::t_div_req i_req,
    output tutk_pkg::t_div_rsp o_rsp
);
    import tutk_pkg::*;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_dvs;

    logic [RATE_W:0]   w_trial;
    logic              w_ge;
    logic [RATE_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_STEPS;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_busy <= r_cnt != CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[RATE_W-1:0] : w_trial[RATE_W-1:0];
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// ===== sv/tick_to_utc_time_keeper_top.sv =====
// channel  | direction | handshake                  | payload
// in       | to block  | i_in_valid / o_in_stall    | command, ticks, new seconds, privilege
// out      | from block| o_out_valid / i_out_stall  | seconds, microseconds, status
// cfg      | to block  | i_cfg_we                   | tick rate
//
// one transaction at a time; a posix or utc read runs the bit-serial divider
// once for seconds and once for microseconds, a set only once for seconds
// the leap-second pass takes one threshold per cycle
// synchronous active-low reset; boot time clears to 0, tick rate to 60
// a finished result sits in the output register while the next transaction
// is taken in; the sequencer waits at its output step only if that register
// is still full and the receiver is stalling it
// Top level: microcoded sequencer and datapath. Depends on tutk_pkg, tutk_div.
module tick_to_utc_time_keeper_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tutk_pkg::RATE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tutk_pkg::CMD_W-1:0]   i_command,
    input  logic [tutk_pkg::TICK_W-1:0]  i_ticks_since_boot,
    input  logic [tutk_pkg::SEC_W-1:0]   i_new_seconds,
    input  logic                         i_is_privileged,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [tutk_pkg::SEC_W-1:0]   o_seconds,
    output logic [tutk_pkg::USEC_W-1:0]  o_microseconds,
    output logic                         o_status
);
    import tutk_pkg::*;

    t_step                 r_step, n_step;
    t_uword                w_uw;
    logic                  w_hold;
    logic                  w_branch;

    logic [RATE_W-1:0]     r_rate;
    logic [SEC_W-1:0]      r_boot;
    logic [CMD_W-1:0]      r_cmd;
    logic [TICK_W-1:0]     r_ticks;
    logic [SEC_W-1:0]      r_newsec;
    logic                  r_priv;
    logic [TICK_W-1:0]     r_elapsed;
    logic [RATE_W-1:0]     r_rem;
    logic [DIVD_W-1:0]     r_prod;
    logic [SEC_W-1:0]      r_secs;
    logic [USEC_W-1:0]     r_usec;
    logic                  r_status;
    logic [LEAP_IDX_W-1:0] r_leap_idx;

    logic                  r_out_valid;
    logic [SEC_W-1:0]      r_out_secs;
    logic [USEC_W-1:0]     r_out_usec;
    logic                  r_out_status;

    logic                  w_in_accept;
    logic                  w_out_free;
    logic [RATE_W-1:0]     w_hz;
    logic [TICK_W:0]       w_sum;
    logic [SEC_W-1:0]      w_sum_sat;
    logic [SEC_W-1:0]      w_secs_inc;
    logic                  w_leap_gt;
    logic [TICK_W-1:0]     w_newsec_ext;
    logic [TICK_W-1:0]     w_set_diff;

    t_div_req              w_div_req;
    t_div_rsp              w_div_rsp;

    tutk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_in_stall  = r_step != S_WAIT;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // a zero rate counts as one tick per second
    assign w_hz = (r_rate == '0) ? RATE_W'(1) : r_rate;

    assign w_sum        = {2'b00, r_boot} + {1'b0, r_elapsed};
    assign w_sum_sat    = (w_sum > (TICK_W+1)'(SEC_MAX)) ? SEC_MAX : w_sum[SEC_W-1:0];
    assign w_secs_inc   = (r_secs == SEC_MAX) ? r_secs : r_secs + SEC_W'(1);
    assign w_leap_gt    = r_secs > leap_limit(r_leap_idx);
    assign w_newsec_ext = {1'b0, r_newsec};
    assign w_set_diff   = w_newsec_ext - r_elapsed;

    assign w_div_req.start    = (w_uw.op == OP_DIV_TICKS) || (w_uw.op == OP_DIV_PROD);
    assign w_div_req.dividend = (w_uw.op == OP_DIV_TICKS) ? DIVD_W'(r_ticks) : r_prod;
    assign w_div_req.divisor  = w_hz;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_uw = ucode(r_step);
        case (w_uw.hold)
            HOLD_NONE:        w_hold = 1'b0;
            HOLD_NO_INPUT:    w_hold = !w_in_accept;
            HOLD_DIV_BUSY:    w_hold = w_div_rsp.busy;
            HOLD_LEAP_MORE:   w_hold = r_leap_idx != LEAP_LAST;
            HOLD_OUT_BLOCKED: w_hold = !w_out_free;
            default:          w_hold = 1'b0;
        endcase
        case (w_uw.br)
            BR_NONE:    w_branch = 1'b0;
            BR_ALWAYS:  w_branch = 1'b1;
            BR_IS_SET:  w_branch = r_cmd == CMD_SET;
            BR_NOT_UTC: w_branch = r_cmd != CMD_UTC;
            default:    w_branch = 1'b0;
        endcase
        if (w_hold) begin
            n_step = r_step;
        end else if (w_branch) begin
            n_step = w_uw.target;
        end else begin
            n_step = t_step'(r_step + 4'd1);
        end
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_boot <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rate <= i_cfg_data;
            end
            if (w_uw.op == OP_SET && r_priv) begin
                r_boot <= (r_elapsed > w_newsec_ext) ? '0 : w_set_diff[SEC_W-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_cmd    <= i_command;
            r_ticks  <= i_ticks_since_boot;
            r_newsec <= i_new_seconds;
            r_priv   <= i_is_privileged;
        end
        case (w_uw.op)
            OP_SAVE_QR: begin
                r_elapsed <= w_div_rsp.quo[TICK_W-1:0];
                r_rem     <= w_div_rsp.rem;
            end
            OP_MUL: begin
                r_secs   <= w_sum_sat;
                r_status <= STATUS_OK;
                r_prod   <= DIVD_W'(r_rem) * DIVD_W'(USEC_PER_SEC);
            end
            OP_SAVE_USEC: begin
                r_usec     <= w_div_rsp.quo[USEC_W-1:0];
                r_leap_idx <= '0;
            end
            OP_LEAP: begin
                if (w_leap_gt) begin
                    r_secs <= w_secs_inc;
                end
                if (r_leap_idx != LEAP_LAST) begin
                    r_leap_idx <= r_leap_idx + LEAP_IDX_W'(1);
                end
            end
            OP_SET: begin
                r_secs   <= '0;
                r_usec   <= '0;
                r_status <= r_priv ? STATUS_OK : STATUS_DENIED;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.op == OP_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.op == OP_EMIT && w_out_free) begin
            r_out_secs   <= r_secs;
            r_out_usec   <= r_usec;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_seconds      = r_out_secs;
    assign o_microseconds = r_out_usec;
    assign o_status       = r_out_status;

`ifndef ASSERT_OFF
    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> r_step == S_DIV1)
        else $error("transaction accepted but sequencer did not start the divider");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider restarted while busy");

    a_leap_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == S_LEAP |-> r_leap_idx <= LEAP_LAST)
        else $error("leap index out of range");

    a_denied_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STATUS_DENIED) |->
            (o_seconds == '0 && o_microseconds == '0))
        else $error("denied set returned nonzero time");
`endif

endmodule

// ===== sim/tutk_time_checker.sv =====
`timescale 1ns / 100ps
// tutk_time_checker: watches the query, reply and tick-rate ports of
// tick_to_utc_time_keeper_top, predicts every reply and compares them in order.
// Depends on tutk_pkg.
module tutk_time_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tutk_pkg::RATE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [tutk_pkg::CMD_W-1:0]   i_command,
    input  logic [tutk_pkg::TICK_W-1:0]  i_ticks,
    input  logic [tutk_pkg::SEC_W-1:0]   i_new_seconds,
    input  logic                         i_privileged,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [tutk_pkg::SEC_W-1:0]   i_seconds,
    input  logic [tutk_pkg::USEC_W-1:0]  i_microseconds,
    input  logic                         i_status,
    output int                           o_fail_count,
    output int                           o_pending
);
    import tutk_pkg::*;

    localparam int LEAP_COUNT   = 27;
    localparam int REPORT_LIMIT = 10;

    // end of the last second before each leap second, ascending
    localparam logic [SEC_W-1:0] LEAP_EDGES [LEAP_COUNT] = '{
        31'd78796799,   31'd94694399,   31'd126230399,  31'd157766399,
        31'd189302399,  31'd220924799,  31'd252460799,  31'd283996799,
        31'd315532799,  31'd362793599,  31'd394329599,  31'd425865599,
        31'd489023999,  31'd567993599,  31'd631151999,  31'd662687999,
        31'd709948799,  31'd741484799,  31'd773020799,  31'd820454399,
        31'd867715199,  31'd915148799,  31'd1136073599, 31'd1230767999,
        31'd1341100799, 31'd1435708799, 31'd1483228799
    };

    typedef struct packed {
        logic [SEC_W-1:0]  secs;
        logic [USEC_W-1:0] usec;
        logic              status;
    } t_time_reply;

    t_time_reply       expected_replies [$];
    logic [RATE_W-1:0] tick_rate = RATE_RESET;
    logic [SEC_W-1:0]  boot_secs = '0;
    int                fails     = 0;

    function automatic logic [SEC_W-1:0] add_clamped(input logic [SEC_W-1:0] a,
                                                     input logic [TICK_W-1:0] b);
        logic [TICK_W:0] sum;
        sum = 33'(a) + 33'(b);
        return (sum > 33'(SEC_MAX)) ? SEC_MAX : sum[SEC_W-1:0];
    endfunction

    // updates boot_secs on a privileged set
    function automatic t_time_reply predict_reply(input logic [CMD_W-1:0]  cmd,
                                                  input logic [TICK_W-1:0] ticks,
                                                  input logic [SEC_W-1:0]  newsec,
                                                  input logic              priv);
        t_time_reply       r;
        logic [TICK_W-1:0] hz;
        logic [TICK_W-1:0] whole;
        logic [TICK_W-1:0] frac;
        logic [63:0]       scaled;
        r = '0;
        // a zero rate counts as one tick per second
        hz    = (tick_rate == '0) ? 32'd1 : 32'(tick_rate);
        whole = ticks / hz;
        frac  = ticks % hz;
        if (cmd == CMD_SET) begin
            if (!priv) begin
                r.status = STATUS_DENIED;
            end else begin
                boot_secs = (whole > 32'(newsec)) ? '0 : newsec - whole[SEC_W-1:0];
            end
        end else begin
            r.secs   = add_clamped(boot_secs, whole);
            scaled   = (64'(frac) * 64'(USEC_PER_SEC)) / 64'(hz);
            r.usec   = scaled[USEC_W-1:0];
            r.status = STATUS_OK;
            if (cmd == CMD_UTC) begin
                // each edge sees the value already raised by the earlier ones
                for (int i = 0; i < LEAP_COUNT; i++) begin
                    if (r.secs > LEAP_EDGES[i]) r.secs = add_clamped(r.secs, 32'd1);
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_time_reply got;
        t_time_reply want;
        if (!i_rst_n) begin
            expected_replies.delete();
            tick_rate = RATE_RESET;
            boot_secs = '0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = {i_seconds, i_microseconds, i_status};
                if (expected_replies.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("%0t: unexpected reply sec %0d usec %0d status %0d",
                                 $realtime, got.secs, got.usec, got.status);
                end else begin
                    want = expected_replies.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("%0t: mismatch, want %0d %0d %0d, got %0d %0d %0d",
                                     $realtime, want.secs, want.usec, want.status,
                                     got.secs, got.usec, got.status);
                    end
                end
            end
            if (i_cfg_we) tick_rate = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_replies.push_back(predict_reply(i_command, i_ticks,
                                                         i_new_seconds, i_privileged));
        end
        o_pending    <= expected_replies.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/tb_tick_to_utc_time_keeper_top.sv =====
`timescale 1ns / 100ps
// Testbench top for tick_to_utc_time_keeper_top: clock, reset, time queries,
// tick-rate phases, output stall pattern and the verdict.
// Depends on tutk_pkg, tutk_time_checker and the block itself.
module tb_tick_to_utc_time_keeper_top;
    import tutk_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused code, reads as posix
    localparam int SETTLE_CYCLES     = 150;
    localparam int CYCLE_LIMIT       = 1000000;
    localparam int PHASE_COUNT       = 7;
    localparam int QUERIES_PER_PHASE = 120;

    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_RUNS   = 2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TICK_W-1:0] ticks;
        logic [SEC_W-1:0]  newsec;
        logic              priv;
    } t_query;

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_cfg_we           = 1'b0;
    logic [RATE_W-1:0] i_cfg_data         = '0;
    logic              i_in_valid         = 1'b0;
    logic [CMD_W-1:0]  i_command          = '0;
    logic [TICK_W-1:0] i_ticks_since_boot = '0;
    logic [SEC_W-1:0]  i_new_seconds      = '0;
    logic              i_is_privileged    = 1'b0;
    logic              i_out_stall        = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [SEC_W-1:0]  o_seconds;
    logic [USEC_W-1:0] o_microseconds;
    logic              o_status;

    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                burst_left  = 0;
    bit                quiet       = 1'b0;
    logic [RATE_W-1:0] cur_rate    = RATE_RESET;
    int                stall_mode  = STALL_NONE;
    int                mode_left   = 0;
    int                run_left    = 0;

    tick_to_utc_time_keeper_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_command          (i_command),
        .i_ticks_since_boot (i_ticks_since_boot),
        .i_new_seconds      (i_new_seconds),
        .i_is_privileged    (i_is_privileged),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_seconds          (o_seconds),
        .o_microseconds     (o_microseconds),
        .o_status           (o_status)
    );

    tutk_time_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_ticks        (i_ticks_since_boot),
        .i_new_seconds  (i_new_seconds),
        .i_privileged   (i_is_privileged),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_seconds      (o_seconds),
        .i_microseconds (o_microseconds),
        .i_status       (o_status),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tick_to_utc_time_keeper_top test failed");
            $finish;
        end
    end

    // receiver: switches between no stall, random stall and long stall runs
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
            mode_left  <= $urandom_range(100, 800);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (stall_mode)
            STALL_NONE: begin
                i_out_stall <= 1'b0;
            end
            STALL_RANDOM: begin
                i_out_stall <= ($urandom_range(0, 99) < 40);
            end
            default: begin
                if (run_left == 0) begin
                    i_out_stall <= ~i_out_stall;
                    run_left    <= $urandom_range(1, 25);
                end else begin
                    run_left <= run_left - 1;
                end
            end
        endcase
    end

    // drives one transaction and returns at the edge that accepts it
    task automatic send_query(input t_query q);
        int gap;
        if (burst_left == 0) begin
            gap = quiet ? 0 : $urandom_range(0, 150);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        i_in_valid         <= 1'b1;
        i_command          <= q.cmd;
        i_ticks_since_boot <= q.ticks;
        i_new_seconds      <= q.newsec;
        i_is_privileged    <= q.priv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // hold off until every reply is back and the sequencer has gone quiet
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= rate;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_rate   = rate;
    endtask

    function automatic t_query random_query(input logic [RATE_W-1:0] rate);
        t_query      q;
        int unsigned pick;
        int unsigned hz;
        hz   = (rate == '0) ? 1 : rate;
        pick = $urandom_range(0, 99);
        if (pick < 30)      q.cmd = CMD_POSIX;
        else if (pick < 70) q.cmd = CMD_UTC;
        else if (pick < 95) q.cmd = CMD_SET;
        else                q.cmd = CMD_SPARE;
        q.priv = ($urandom_range(0, 99) < 85);
        pick = $urandom_range(0, 9);
        if (pick < 6)      q.newsec = SEC_W'($urandom);
        else if (pick < 8) q.newsec = SEC_W'($urandom_range(70000000, 1600000000));
        else if (pick < 9) q.newsec = SEC_MAX - SEC_W'($urandom_range(0, 5000));
        else               q.newsec = SEC_W'($urandom_range(0, 5000));
        pick = $urandom_range(0, 9);
        if (pick < 5)      q.ticks = $urandom;
        else if (pick < 7) q.ticks = $urandom_range(0, hz * 20);
        else if (pick < 9) q.ticks = 32'hFFFF_FFFF - $urandom_range(0, hz * 4);
        else               q.ticks = $urandom * hz + $urandom_range(0, 2) - 1;  // second edges
        return q;
    endfunction

    initial begin
        int phase;
        int n;
        logic [RATE_W-1:0] rate;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset tick rate of 60
        send_query(t_query'{CMD_POSIX, 32'd0,          31'd0,      1'b0});
        send_query(t_query'{CMD_POSIX, 32'hFFFF_FFFF,  31'd0,      1'b1});
        send_query(t_query'{CMD_UTC,   32'hFFFF_FFFF,  SEC_MAX,    1'b0});
        send_query(t_query'{CMD_SPARE, 32'd59,         31'd0,      1'b0});
        send_query(t_query'{CMD_SET,   32'd0,          SEC_MAX,    1'b0});  // denied
        send_query(t_query'{CMD_SET,   32'd0,          31'd78796799, 1'b1});
        send_query(t_query'{CMD_UTC,   32'd0,          31'd0,      1'b0});  // on the first edge
        send_query(t_query'{CMD_UTC,   32'd60,         31'd0,      1'b0});  // just past it
        send_query(t_query'{CMD_SET,   32'd0,          31'd94694398, 1'b1});
        send_query(t_query'{CMD_UTC,   32'd0,          31'd0,      1'b0});  // lifted onto next edge
        send_query(t_query'{CMD_UTC,   32'd60,         31'd0,      1'b1});  // chained leaps
        send_query(t_query'{CMD_SET,   32'd0,          31'd1483228799, 1'b1});
        send_query(t_query'{CMD_UTC,   32'd120,        31'd0,      1'b0});  // every leap second
        send_query(t_query'{CMD_SET,   32'd0,          SEC_MAX,    1'b1});
        send_query(t_query'{CMD_POSIX, 32'hFFFF_FFFF,  31'd0,      1'b0});  // clamped sum
        send_query(t_query'{CMD_UTC,   32'd0,          31'd0,      1'b0});  // clamped leaps
        send_query(t_query'{CMD_SET,   32'hFFFF_FFFF,  31'd5,      1'b1});  // set before boot
        send_query(t_query'{CMD_POSIX, 32'd600,        31'd0,      1'b1});
        send_query(t_query'{CMD_SET,   32'd600,        31'd10,     1'b1});  // elapsed equals new
        send_query(t_query'{CMD_SPARE, 32'd61,         SEC_MAX,    1'b1});
        send_query(t_query'{CMD_SET,   32'd0,          31'd0,      1'b1});
        send_query(t_query'{CMD_UTC,   32'hFFFF_FFFF,  31'd0,      1'b1});
        wait_idle();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0:       rate = 16'd1;
                1:       rate = 16'hFFFF;
                2:       rate = 16'd0;      // treated as one tick per second
                3:       rate = RATE_W'($urandom_range(1, 65535));
                4:       rate = 16'd1000;
                5:       rate = RATE_W'($urandom);
                default: rate = 16'd100;
            endcase
            write_rate(rate);
            quiet = ($urandom_range(0, 3) == 0);
            for (n = 0; n < QUERIES_PER_PHASE; n++) begin
                if (n == QUERIES_PER_PHASE / 2) wait_idle();
                send_query(random_query(cur_rate));
            end
            wait_idle();
        end

        if (fail_count == 0 && pending == 0)
            $display("tick_to_utc_time_keeper_top test passed");
        else
            $display("tick_to_utc_time_keeper_top test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/tutk_pkg.sv
sv/tutk_div.sv
sv/tick_to_utc_time_keeper_top.sv
sim/tutk_time_checker.sv
sim/tb_tick_to_utc_time_keeper_top.sv
